// ===== rtl/gamepad_stick_to_keys_mapper_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the gamepad stick-to-keys mapper
// Shared property forms for the checker: same-cycle and next-cycle implication.
// ----------------------------------------------------------------------------
`ifndef GAMEPAD_STICK_TO_KEYS_MAPPER_UNIT_MACROS_SVH
`define GAMEPAD_STICK_TO_KEYS_MAPPER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GSK_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GSK_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/gsk_pkg.sv =====
// ----------------------------------------------------------------------------
// Gamepad stick-to-keys mapper package
// Button layout, stick thresholds, register indexes and beat types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gsk_pkg;

    // Number of configurable key masks.
    localparam int unsigned NUM_MAPS = 8;

    // Register indexes on the configuration port.
    localparam logic [2:0] CFG_MAP_SELECT   = 3'd0;
    localparam logic [2:0] CFG_MAP_START    = 3'd1;
    localparam logic [2:0] CFG_MAP_LTRIG    = 3'd2;
    localparam logic [2:0] CFG_MAP_RTRIG    = 3'd3;
    localparam logic [2:0] CFG_MAP_TRIANGLE = 3'd4;
    localparam logic [2:0] CFG_MAP_CIRCLE   = 3'd5;
    localparam logic [2:0] CFG_MAP_CROSS    = 3'd6;
    localparam logic [2:0] CFG_MAP_SQUARE   = 3'd7;

    // Input action codes.
    localparam logic ACT_INIT  = 1'b0;
    localparam logic ACT_FRAME = 1'b1;

    // Bit positions in the button word.
    localparam int unsigned BTN_UP    = 4;
    localparam int unsigned BTN_RIGHT = 5;
    localparam int unsigned BTN_DOWN  = 6;
    localparam int unsigned BTN_LEFT  = 7;

    // Button bit that enables each key mask, mask 0 in the lowest entry.
    localparam logic [NUM_MAPS-1:0][4:0] MAP_BUTTON_BIT = {
        5'd15, 5'd14, 5'd13, 5'd12, 5'd9, 5'd8, 5'd3, 5'd0
    };

    // Directions kept in the key word.
    localparam logic [31:0] DIR_MASK = 32'h0000_00F0;

    // Stick dead zone and full-scale magnitude.
    localparam logic [7:0] STICK_LOW  = 8'd64;
    localparam logic [7:0] STICK_HIGH = 8'd192;
    localparam logic [8:0] MAG_FULL   = 9'd256;

    // One accepted input beat.
    typedef struct packed {
        logic        action;
        logic [31:0] buttons;
        logic [7:0]  stick_x;
        logic [7:0]  stick_y;
    } item_t;

    // One result beat.
    typedef struct packed {
        logic [31:0] keys;
        logic [31:0] previous_keys;
        logic [8:0]  magnitude_x;
        logic [8:0]  magnitude_y;
        logic        analog_enabled;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/gamepad_stick_to_keys_mapper_unit.sv =====
// ----------------------------------------------------------------------------
// Gamepad stick-to-keys mapper
// Turns controller samples into mapped key words and stick magnitudes.
// ----------------------------------------------------------------------------
//  Channel   Dir  Payload
//  s_axis    in   tuser: action; tdata: buttons, stick_x, stick_y
//  m_axis    out  tdata: keys, previous_keys, magnitude_x, magnitude_y, analog
//  cfg       in   cfg_wr_en, cfg_index, cfg_data (eight 32-bit key masks)
//
//  One beat per cycle sustained while the output is not stalled; a taken beat is
//  held in the input register, then in the result register, from which it leaves.
//  The state (analog enable, current and previous keys) updates as a beat moves
//  from the input register to the result register, so beats chain in order.
//  A stalled result holds; the input register still takes one more beat.
//  Reset clears valids, state and key masks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gamepad_stick_to_keys_mapper_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Input stream.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,   // buttons[31:0], stick_x[39:32], stick_y[47:40]
    input  wire logic        s_axis_tuser,   // action
    // Output stream.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [87:0]      m_axis_tdata,   // keys[31:0], previous_keys[63:32],
                                             // magnitude_x[72:64], magnitude_y[81:73],
                                             // analog_enabled[82], zero[87:83]
    // Configuration writes.
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    logic                 in_valid_reg;
    gsk_pkg::item_t       in_item_reg;
    logic                 out_valid_reg;
    gsk_pkg::result_t     out_reg;
    logic                 analog_on_reg;
    logic                 analog_on_next;
    logic [31:0]          current_keys_reg;
    logic [31:0]          current_keys_next;
    logic [31:0]          last_keys_reg;
    logic [31:0]          key_map_reg [gsk_pkg::NUM_MAPS];
    gsk_pkg::result_t     out_next;
    logic                 advance;

    // Handshake: the input register moves on when the result register is free.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, out_reg.analog_enabled, out_reg.magnitude_y,
                            out_reg.magnitude_x, out_reg.previous_keys, out_reg.keys};

    // Key mask registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < gsk_pkg::NUM_MAPS; i++)
            begin
                key_map_reg[i] <= '0;
            end
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                gsk_pkg::CFG_MAP_SELECT:   key_map_reg[0] <= cfg_data;
                gsk_pkg::CFG_MAP_START:    key_map_reg[1] <= cfg_data;
                gsk_pkg::CFG_MAP_LTRIG:    key_map_reg[2] <= cfg_data;
                gsk_pkg::CFG_MAP_RTRIG:    key_map_reg[3] <= cfg_data;
                gsk_pkg::CFG_MAP_TRIANGLE: key_map_reg[4] <= cfg_data;
                gsk_pkg::CFG_MAP_CIRCLE:   key_map_reg[5] <= cfg_data;
                gsk_pkg::CFG_MAP_CROSS:    key_map_reg[6] <= cfg_data;
                gsk_pkg::CFG_MAP_SQUARE:   key_map_reg[7] <= cfg_data;
                default:                   key_map_reg[0] <= key_map_reg[0];
            endcase
        end
    end

    // Mapping logic for the beat in the input register.
    always_comb
    begin
        logic [31:0] raw;
        logic [31:0] keys;
        logic [8:0]  mag_x;
        logic [8:0]  mag_y;
        logic [7:0]  diff_x;
        logic [7:0]  diff_y;
        logic        init_ok;

        raw     = in_item_reg.buttons;
        mag_x   = '0;
        mag_y   = '0;
        diff_x  = '0;
        diff_y  = '0;
        init_ok = (in_item_reg.stick_x >= gsk_pkg::STICK_LOW)
               && (in_item_reg.stick_x <= gsk_pkg::STICK_HIGH)
               && (in_item_reg.stick_y >= gsk_pkg::STICK_LOW)
               && (in_item_reg.stick_y <= gsk_pkg::STICK_HIGH);

        // Stick deflection beyond the dead zone, when enabled.
        if (analog_on_reg)
        begin
            if (in_item_reg.stick_x < gsk_pkg::STICK_LOW)
            begin
                raw[gsk_pkg::BTN_LEFT] = 1'b1;
                diff_x = gsk_pkg::STICK_LOW - in_item_reg.stick_x;
                mag_x  = {diff_x[6:0], 2'b00};
            end
            else if (in_item_reg.stick_x > gsk_pkg::STICK_HIGH)
            begin
                raw[gsk_pkg::BTN_RIGHT] = 1'b1;
                diff_x = in_item_reg.stick_x - gsk_pkg::STICK_HIGH;
                mag_x  = {diff_x[6:0], 2'b00};
            end
            if (in_item_reg.stick_y < gsk_pkg::STICK_LOW)
            begin
                raw[gsk_pkg::BTN_UP] = 1'b1;
                diff_y = gsk_pkg::STICK_LOW - in_item_reg.stick_y;
                mag_y  = {diff_y[6:0], 2'b00};
            end
            else if (in_item_reg.stick_y > gsk_pkg::STICK_HIGH)
            begin
                raw[gsk_pkg::BTN_DOWN] = 1'b1;
                diff_y = in_item_reg.stick_y - gsk_pkg::STICK_HIGH;
                mag_y  = {diff_y[6:0], 2'b00};
            end
        end

        // Directions pass through; mapped buttons OR in their masks.
        keys = raw & gsk_pkg::DIR_MASK;
        for (int i = 0; i < gsk_pkg::NUM_MAPS; i++)
        begin
            if (raw[gsk_pkg::MAP_BUTTON_BIT[i]])
            begin
                keys = keys | key_map_reg[i];
            end
        end

        // Digital directions give full scale when no stick magnitude is set.
        if ((mag_x == '0) && (mag_y == '0))
        begin
            if (raw[gsk_pkg::BTN_UP] || raw[gsk_pkg::BTN_DOWN])
            begin
                mag_y = gsk_pkg::MAG_FULL;
            end
            if (raw[gsk_pkg::BTN_RIGHT] || raw[gsk_pkg::BTN_LEFT])
            begin
                mag_x = gsk_pkg::MAG_FULL;
            end
        end

        if (in_item_reg.action == gsk_pkg::ACT_INIT)
        begin
            analog_on_next             = init_ok;
            current_keys_next          = current_keys_reg;
            out_next.keys              = current_keys_reg;
            out_next.previous_keys     = last_keys_reg;
            out_next.magnitude_x       = '0;
            out_next.magnitude_y       = '0;
            out_next.analog_enabled    = init_ok;
        end
        else
        begin
            analog_on_next             = analog_on_reg;
            current_keys_next          = keys;
            out_next.keys              = keys;
            out_next.previous_keys     = current_keys_reg;
            out_next.magnitude_x       = mag_x;
            out_next.magnitude_y       = mag_y;
            out_next.analog_enabled    = analog_on_reg;
        end
    end

    // Valid flags and state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            analog_on_reg    <= 1'b0;
            current_keys_reg <= '0;
            last_keys_reg    <= '0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg    <= 1'b1;
                analog_on_reg    <= analog_on_next;
                current_keys_reg <= current_keys_next;
                if (in_item_reg.action == gsk_pkg::ACT_FRAME)
                begin
                    last_keys_reg <= current_keys_reg;
                end
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_item_reg.action  <= s_axis_tuser;
            in_item_reg.buttons <= s_axis_tdata[31:0];
            in_item_reg.stick_x <= s_axis_tdata[39:32];
            in_item_reg.stick_y <= s_axis_tdata[47:40];
        end
        if (advance)
        begin
            out_reg <= out_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/gsk_checker.sv =====
// ----------------------------------------------------------------------------
// Gamepad stick-to-keys mapper checker
// Port-level checks on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "gamepad_stick_to_keys_mapper_unit_macros.svh"

module gsk_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [87:0] m_axis_tdata
);

    logic [8:0] mag_x;
    logic [8:0] mag_y;
    logic       analog;

    assign mag_x  = m_axis_tdata[72:64];
    assign mag_y  = m_axis_tdata[81:73];
    assign analog = m_axis_tdata[82];

    // A stalled result beat stays and holds its payload.
    `GSK_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result beat changed while stalled")

    // Without analog handling a magnitude is zero or full scale.
    `GSK_ASSERT_IMPL(a_digital_mag, clk, rst_n, m_axis_tvalid && !analog, (mag_x == 9'd0 || mag_x == 9'd256) && (mag_y == 9'd0 || mag_y == 9'd256), "partial magnitude with analog disabled")

    // A partial horizontal deflection always shows a left or right key.
    `GSK_ASSERT_IMPL(a_x_dir, clk, rst_n, m_axis_tvalid && mag_x != 9'd0 && mag_x != 9'd256, m_axis_tdata[5] || m_axis_tdata[7], "horizontal magnitude without direction key")

    // A partial vertical deflection always shows an up or down key.
    `GSK_ASSERT_IMPL(a_y_dir, clk, rst_n, m_axis_tvalid && mag_y != 9'd0 && mag_y != 9'd256, m_axis_tdata[4] || m_axis_tdata[6], "vertical magnitude without direction key")

endmodule

bind gamepad_stick_to_keys_mapper_unit gsk_checker u_gsk_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
